// ===== rtl/kvct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvct_pkg
// Shared types, character classes and event codes of the key/value
// configuration tokenizer.
// ----------------------------------------------------------------------------
package kvct_pkg;

    localparam int unsigned MaxEvents = 3;

    localparam logic [7:0] ChTab       = 8'h09;
    localparam logic [7:0] ChNewline   = 8'h0a;
    localparam logic [7:0] ChVtab      = 8'h0b;
    localparam logic [7:0] ChFormfeed  = 8'h0c;
    localparam logic [7:0] ChReturn    = 8'h0d;
    localparam logic [7:0] ChBackspace = 8'h08;
    localparam logic [7:0] ChSpace     = 8'h20;
    localparam logic [7:0] ChDquote    = 8'h22;
    localparam logic [7:0] ChHash      = 8'h23;
    localparam logic [7:0] ChSquote    = 8'h27;
    localparam logic [7:0] ChMinus     = 8'h2d;
    localparam logic [7:0] ChColon     = 8'h3a;
    localparam logic [7:0] ChEquals    = 8'h3d;
    localparam logic [7:0] ChBackslash = 8'h5c;
    localparam logic [7:0] ChCaret     = 8'h5e;
    localparam logic [7:0] ChUnder     = 8'h5f;

    typedef enum logic [2:0] {
        EV_NAME_BYTE  = 3'd0,
        EV_NAME_END   = 3'd1,
        EV_VALUE_BYTE = 3'd2,
        EV_VALUE_END  = 3'd3,
        EV_FINISHED   = 3'd4,
        EV_FAILED     = 3'd5
    } t_ev_kind;

    typedef struct packed {
        t_ev_kind   kind;
        logic [7:0] data;
        logic       last;
    } t_event;

    typedef struct packed {
        logic       step;
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_step_req;

    typedef struct packed {
        t_event [MaxEvents-1:0] ev;
        logic [1:0]             cnt;
    } t_step_res;

    function automatic t_event ev_make(input t_ev_kind kind, input logic [7:0] data);
        t_event e;
        e.kind = kind;
        e.data = data;
        e.last = 1'b0;
        return e;
    endfunction

    function automatic logic is_hspace(input logic [7:0] c);
        return (c == ChTab) || (c == ChSpace);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return is_hspace(c) || (c == ChNewline) || (c == ChVtab) ||
               (c == ChFormfeed) || (c == ChReturn) || (c == ChBackspace);
    endfunction

    function automatic logic is_first(input logic [7:0] c);
        return (c == ChUnder) || ((c >= 8'h61) && (c <= 8'h7a)) ||
               ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return is_first(c) || ((c >= 8'h30) && (c <= 8'h39)) ||
               (c == ChColon) || (c == ChCaret) || (c == ChMinus);
    endfunction

endpackage

// ===== rtl/kvct_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvct_if
// Valid/ready channels for text bytes in and parse events out.
// ----------------------------------------------------------------------------
interface kvct_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface kvct_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] event_byte;
    logic       last_event;

    modport source (output valid, output event_kind, output event_byte,
                    output last_event, input ready);
    modport sink   (input valid, input event_kind, input event_byte,
                    input last_event, output ready);
endinterface

// ===== rtl/kvct_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvct_core
// Parse state and the per-byte step logic that turns one text byte or the
// end mark into up to three events.
// ----------------------------------------------------------------------------
module kvct_core
    import kvct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_step_req i_req,
    output t_step_res o_res
);

    typedef enum logic [9:0] {
        M_SKIP       = 10'b00_0000_0001,
        M_COMMENT    = 10'b00_0000_0010,
        M_NAME       = 10'b00_0000_0100,
        M_PRE        = 10'b00_0000_1000,
        M_DELIM      = 10'b00_0001_0000,
        M_PLAIN      = 10'b00_0010_0000,
        M_PLAIN_ESC  = 10'b00_0100_0000,
        M_QUOTED     = 10'b00_1000_0000,
        M_QUOTED_ESC = 10'b01_0000_0000,
        M_DONE       = 10'b10_0000_0000
    } t_mode;

    t_mode r_mode, n_mode;
    logic  r_colon, n_colon;
    logic  r_single, n_single;

    always_comb begin
        logic [7:0] c;
        logic [7:0] q;
        logic       do_after;
        logic       am_pre;
        logic [1:0] k;
        t_step_res  res;

        c        = i_req.text_byte;
        q        = r_single ? ChSquote : ChDquote;
        do_after = 1'b0;
        am_pre   = 1'b1;
        k        = 2'd0;
        res      = '0;
        n_mode   = r_mode;
        n_colon  = r_colon;
        n_single = r_single;

        if (i_req.end_of_text) begin
            unique case (r_mode)
                M_DONE: begin
                end
                M_QUOTED_ESC: begin
                    res.ev[0] = ev_make(EV_FAILED, 8'h00);
                    res.cnt   = 2'd1;
                end
                M_NAME: begin
                    res.ev[0] = ev_make(EV_NAME_END, 8'h00);
                    res.ev[1] = ev_make(EV_VALUE_END, 8'h00);
                    res.ev[2] = ev_make(EV_FINISHED, 8'h00);
                    res.cnt   = 2'd3;
                end
                M_PRE, M_DELIM, M_PLAIN, M_PLAIN_ESC, M_QUOTED: begin
                    res.ev[0] = ev_make(EV_VALUE_END, 8'h00);
                    res.ev[1] = ev_make(EV_FINISHED, 8'h00);
                    res.cnt   = 2'd2;
                end
                default: begin
                    res.ev[0] = ev_make(EV_FINISHED, 8'h00);
                    res.cnt   = 2'd1;
                end
            endcase
            n_mode   = M_SKIP;
            n_colon  = 1'b0;
            n_single = 1'b0;
        end else begin
            unique case (r_mode)
                M_DONE: begin
                end
                M_COMMENT: begin
                    if (c == ChNewline) begin
                        n_mode = M_SKIP;
                    end
                end
                M_NAME: begin
                    if (is_name(c)) begin
                        if (r_colon) begin
                            res.ev[0] = ev_make(EV_NAME_BYTE, ChColon);
                            k         = 2'd1;
                        end
                        if (c == ChColon) begin
                            n_colon = 1'b1;
                            res.cnt = k;
                        end else begin
                            n_colon   = 1'b0;
                            res.ev[k] = ev_make(EV_NAME_BYTE, c);
                            res.cnt   = k + 2'd1;
                        end
                    end else begin
                        res.ev[0] = ev_make(EV_NAME_END, 8'h00);
                        res.cnt   = 2'd1;
                        k         = 2'd1;
                        am_pre    = !r_colon;
                        n_colon   = 1'b0;
                        do_after  = 1'b1;
                    end
                end
                M_PRE: begin
                    do_after = 1'b1;
                end
                M_DELIM: begin
                    am_pre   = 1'b0;
                    do_after = 1'b1;
                end
                M_PLAIN: begin
                    if (c == ChBackslash) begin
                        n_mode = M_PLAIN_ESC;
                    end else if (c == ChNewline) begin
                        n_mode    = M_SKIP;
                        res.ev[0] = ev_make(EV_VALUE_END, 8'h00);
                        res.cnt   = 2'd1;
                    end else begin
                        res.ev[0] = ev_make(EV_VALUE_BYTE, c);
                        res.cnt   = 2'd1;
                    end
                end
                M_PLAIN_ESC: begin
                    if (c == ChNewline) begin
                        res.ev[0] = ev_make(EV_VALUE_BYTE, ChNewline);
                        res.cnt   = 2'd1;
                    end
                    n_mode = M_PLAIN;
                end
                M_QUOTED: begin
                    if (c == ChBackslash) begin
                        n_mode = M_QUOTED_ESC;
                    end else if (c == q) begin
                        n_mode    = M_SKIP;
                        n_single  = 1'b0;
                        res.ev[0] = ev_make(EV_VALUE_END, 8'h00);
                        res.cnt   = 2'd1;
                    end else begin
                        res.ev[0] = ev_make(EV_VALUE_BYTE, c);
                        res.cnt   = 2'd1;
                    end
                end
                M_QUOTED_ESC: begin
                    if (c == ChNewline) begin
                        res.ev[0] = ev_make(EV_VALUE_BYTE, ChSpace);
                        res.cnt   = 2'd1;
                    end else if (c == q) begin
                        res.ev[0] = ev_make(EV_VALUE_BYTE, q);
                        res.cnt   = 2'd1;
                    end
                    n_mode = M_QUOTED;
                end
                default: begin
                    n_mode = M_SKIP;
                    if (c == ChHash) begin
                        n_mode = M_COMMENT;
                    end else if (is_space(c)) begin
                        n_mode = M_SKIP;
                    end else if (is_first(c)) begin
                        n_mode    = M_NAME;
                        n_colon   = 1'b0;
                        res.ev[0] = ev_make(EV_NAME_BYTE, c);
                        res.cnt   = 2'd1;
                    end else begin
                        n_mode    = M_DONE;
                        res.ev[0] = ev_make(EV_FINISHED, 8'h00);
                        res.cnt   = 2'd1;
                    end
                end
            endcase

            // Handling of the byte that follows a name or a delimiter.
            if (do_after) begin
                n_mode = am_pre ? M_PRE : M_DELIM;
                if (is_hspace(c)) begin
                    n_mode = am_pre ? M_PRE : M_DELIM;
                end else if (am_pre && ((c == ChColon) || (c == ChEquals))) begin
                    n_mode = M_DELIM;
                end else if (c == ChNewline) begin
                    n_mode    = M_SKIP;
                    res.ev[k] = ev_make(EV_VALUE_END, 8'h00);
                    res.cnt   = k + 2'd1;
                end else if ((c == ChDquote) || (c == ChSquote)) begin
                    n_single = (c == ChSquote);
                    n_mode   = M_QUOTED;
                end else begin
                    n_mode    = M_PLAIN;
                    res.ev[k] = ev_make(EV_VALUE_BYTE, c);
                    res.cnt   = k + 2'd1;
                end
            end
        end

        if (res.cnt != 2'd0) begin
            res.ev[res.cnt - 2'd1].last = 1'b1;
        end
        o_res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_SKIP;
            r_colon  <= 1'b0;
            r_single <= 1'b0;
        end else if (i_req.step) begin
            r_mode   <= n_mode;
            r_colon  <= n_colon;
            r_single <= n_single;
        end
    end

endmodule

// ===== rtl/keyvalue_config_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyvalue_config_tokenizer
// Streams configuration text one byte per beat and emits name and value events.
// ----------------------------------------------------------------------------
// An input beat is registered in the input register, parsed and then held in the event buffer.
// Throughput: one input beat per cycle while each byte yields at most one
// event and o_event.ready is high; a byte with more events holds input until its last event is read out.
// Reset clears the parse state to between options, empties the input
// register and the three-entry event buffer.
module keyvalue_config_tokenizer
    import kvct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    kvct_text_if.sink   i_text,
    kvct_event_if.source o_event
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eot;

    t_event [MaxEvents-1:0] r_ev;
    logic [1:0]             r_cnt;

    logic      w_pop;
    logic      w_step;
    t_step_req w_req;
    t_step_res w_res;

    assign w_pop  = (r_cnt != 2'd0) && o_event.ready;
    assign w_step = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_event.ready));

    assign i_text.ready = !r_in_valid || w_step;

    assign w_req.step        = w_step;
    assign w_req.text_byte   = r_in_byte;
    assign w_req.end_of_text = r_in_eot;

    kvct_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.ready && i_text.valid) begin
            r_in_byte <= i_text.text_byte;
            r_in_eot  <= i_text.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_step) begin
            r_cnt <= w_res.cnt;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_ev <= w_res.ev;
        end else if (w_pop) begin
            r_ev[0] <= r_ev[1];
            r_ev[1] <= r_ev[2];
        end
    end

    assign o_event.valid      = (r_cnt != 2'd0);
    assign o_event.event_kind = r_ev[0].kind;
    assign o_event.event_byte = r_ev[0].data;
    assign o_event.last_event = r_ev[0].last;

endmodule
